// ===== sv/dmadr_pkg.sv =====
// Shared types and constants for the dual moving-average steering-error block.
package dmadr_pkg;

  localparam int ERR_W     = 16;
  localparam int FRAC_BITS = 15;

  typedef logic [ERR_W-1:0] err_t;

  localparam err_t ERR_MAX  = 16'h7FFF;
  localparam err_t ERR_MIN  = 16'h8000;
  localparam err_t ERR_ZERO = 16'h0000;

endpackage

// ===== sv/dual_moving_average_diff_ratio.sv =====
// Top level: dual moving-average filter with (L-R)/(L+R) steering error.
//
// Input stream s_*: one request carries a left and a right sensor sample.
// Output stream m_*: one result per request, with the Q1.15 steering error
// and the two filtered values.
// Both channels share one window memory (WINDOW entries of {right, left})
// with a registered read; the running sums, write pointer and fill
// count are registers. One shared restoring divider, one quotient bit per
// cycle, produces left average, right average and the error in turn; the
// error division is skipped when either average is zero.
// A new request is taken in the cycle after the result is loaded into the
// output register, so the block takes no new request while it is dividing.
// Reset clears pointer, fill count, sums and handshake state; the window
// memory needs no clearing because a slot is only read back once the ring
// is full. If the receiver stalls, the finished result waits in state DONE
// and the output register holds its last result until it is taken.
module dual_moving_average_diff_ratio
  import dmadr_pkg::*;
#(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // steering_error, left_average, right_average
  output logic [((ERR_W+2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int OUT_TW = ((ERR_W + 2*SB + 7) / 8) * 8;
  localparam int SW     = SB + $clog2(WINDOW);
  localparam int FW     = $clog2(WINDOW + 1);
  localparam int PW     = $clog2(WINDOW);
  localparam int QW     = (SW > FRAC_BITS) ? SW : FRAC_BITS;
  localparam int CW     = $clog2(QW + 1);
  localparam int RW     = SB + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_DIVL = 3'd2;
  localparam logic [2:0] ST_DIVR = 3'd3;
  localparam logic [2:0] ST_DIVE = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]      state;
  logic [PW-1:0]   wpos;
  logic [FW-1:0]   fill;
  logic [SW-1:0]   lsum;
  logic [SW-1:0]   rsum;
  logic [SB-1:0]   lsamp;
  logic [SB-1:0]   rsamp;
  logic [2*SB-1:0] rd_data;
  logic [2*SB-1:0] win_mem [WINDOW];

  logic [RW-1:0]   rem;
  logic [SW-1:0]   dend;
  logic [RW-1:0]   dvsr;
  logic [QW-1:0]   quo;
  logic [CW-1:0]   cnt;
  logic            neg;

  logic [SB-1:0]   avg_l;
  logic [SB-1:0]   avg_r;
  err_t            err;

  logic [SB-1:0]   out_l;
  logic [SB-1:0]   out_r;
  err_t            out_err;

  logic            accept;
  logic            full;
  logic [SW-1:0]   lsum_next;
  logic [SW-1:0]   rsum_next;
  logic [FW-1:0]   fill_next;

  logic [RW:0]     sh;
  logic            ge;
  logic [RW-1:0]   rem_step;
  logic [QW-1:0]   q_step;
  logic            last;

  logic [SB-1:0]   ra;
  logic [SB-1:0]   rb;
  logic [SB:0]     total;
  logic [SB-1:0]   diff;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign full     = (fill == FW'(WINDOW));

  assign lsum_next = lsum - (full ? SW'(rd_data[SB-1:0]) : SW'(0)) + SW'(lsamp);
  assign rsum_next = rsum - (full ? SW'(rd_data[2*SB-1:SB]) : SW'(0)) + SW'(rsamp);
  assign fill_next = full ? fill : fill + FW'(1);

  // one restoring-division step
  assign sh       = {rem, dend[SW-1]};
  assign ge       = (sh >= {1'b0, dvsr});
  assign rem_step = ge ? RW'(sh - {1'b0, dvsr}) : RW'(sh);
  assign q_step   = {quo[QW-2:0], ge};
  assign last     = (cnt == CW'(1));

  // ratio operands, right average straight from the final step
  assign ra    = avg_l;
  assign rb    = q_step[SB-1:0];
  assign total = {1'b0, ra} + {1'b0, rb};
  assign diff  = (ra >= rb) ? ra - rb : rb - ra;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= win_mem[wpos];
    end
    if (state == ST_UPD) begin
      win_mem[wpos] <= {rsamp, lsamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wpos     <= '0;
      fill     <= '0;
      lsum     <= '0;
      rsum     <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            lsamp <= s_tdata[SB-1:0];
            rsamp <= s_tdata[2*SB-1:SB];
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          lsum  <= lsum_next;
          rsum  <= rsum_next;
          fill  <= fill_next;
          wpos  <= (wpos == PW'(WINDOW - 1)) ? '0 : wpos + PW'(1);
          rem   <= '0;
          dend  <= lsum_next;
          dvsr  <= RW'(fill_next);
          quo   <= '0;
          cnt   <= CW'(SW);
          state <= ST_DIVL;
        end
        ST_DIVL: begin
          if (last) begin
            avg_l <= q_step[SB-1:0];
            rem   <= '0;
            dend  <= rsum;
            quo   <= '0;
            cnt   <= CW'(SW);
            state <= ST_DIVR;
          end else begin
            rem  <= rem_step;
            dend <= {dend[SW-2:0], 1'b0};
            quo  <= q_step;
            cnt  <= cnt - CW'(1);
          end
        end
        ST_DIVR: begin
          if (last) begin
            avg_r <= rb;
            neg   <= (ra < rb);
            if (total == '0) begin
              err   <= ERR_ZERO;
              state <= ST_DONE;
            end else if (rb == '0) begin
              err   <= ERR_MAX;
              state <= ST_DONE;
            end else if (ra == '0) begin
              err   <= ERR_MIN;
              state <= ST_DONE;
            end else begin
              rem   <= RW'(diff);
              dend  <= '0;
              dvsr  <= RW'(total);
              quo   <= '0;
              cnt   <= CW'(FRAC_BITS);
              state <= ST_DIVE;
            end
          end else begin
            rem  <= rem_step;
            dend <= {dend[SW-2:0], 1'b0};
            quo  <= q_step;
            cnt  <= cnt - CW'(1);
          end
        end
        ST_DIVE: begin
          if (last) begin
            err   <= neg ? ERR_ZERO - ERR_W'(q_step[FRAC_BITS-1:0])
                         : ERR_W'(q_step[FRAC_BITS-1:0]);
            state <= ST_DONE;
          end else begin
            rem  <= rem_step;
            dend <= {dend[SW-2:0], 1'b0};
            quo  <= q_step;
            cnt  <= cnt - CW'(1);
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_err  <= err;
            out_l    <= avg_l;
            out_r    <= avg_r;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_TW'({out_r, out_l, out_err});

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_UPD)
    else $error("accepted request did not enter update");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW))
    else $error("fill count above window");

  a_warmup_pos: assert property (@(posedge clk) disable iff (rst)
    !full |-> FW'(wpos) == fill)
    else $error("write pointer and fill count disagree during warm-up");

  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> lsum == '0 && rsum == '0)
    else $error("nonzero sum with empty window");

  a_err_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVE |-> cnt <= CW'(FRAC_BITS) && cnt != '0)
    else $error("error division step count out of range");

endmodule

// ===== dv/tb.sv =====
// Testbench for the dual moving-average steering-error block, self-checking.
`timescale 1ns / 100ps

module tb;
  import dmadr_pkg::*;

  localparam int WIN        = 8;
  localparam int SW         = 12;
  localparam int IN_W       = ((2*SW+7)/8)*8;
  localparam int OUT_W      = ((ERR_W+2*SW+7)/8)*8;
  localparam int TOTAL      = 700;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 60;

  typedef enum {
    RUN_WIDE, RUN_SMALL, RUN_STEADY, RUN_RIGHT_DARK, RUN_LEFT_DARK, RUN_DARK, RUN_CLOSE
  } run_kind_t;

  // Windowed filters plus Q1.15 (L-R)/(L+R), compared against the output stream.
  class steering_checker;
    typedef struct {
      err_t          err;
      logic [SW-1:0] left_avg;
      logic [SW-1:0] right_avg;
    } steer_t;

    steer_t        predicted_steer[$];
    logic [SW-1:0] left_ring[WIN];
    logic [SW-1:0] right_ring[WIN];
    int unsigned   slot;
    int unsigned   held;
    int unsigned   left_total;
    int unsigned   right_total;
    int            mismatches;

    function new();
      foreach (left_ring[i]) begin
        left_ring[i]  = '0;
        right_ring[i] = '0;
      end
      slot        = 0;
      held        = 0;
      left_total  = 0;
      right_total = 0;
      mismatches  = 0;
    endfunction

    function err_t q15_balance(int unsigned a, int unsigned b);
      longint unsigned total;
      longint unsigned q;
      total = a + b;
      if (total == 0) return ERR_ZERO;
      if (a >= b) begin
        q = (longint'(a - b) << FRAC_BITS) / total;
        if (q > ERR_MAX) return ERR_MAX;
        return err_t'(q);
      end
      q = (longint'(b - a) << FRAC_BITS) / total;
      return err_t'((64'd1 << ERR_W) - q);
    endfunction

    function void note_request(logic [SW-1:0] l, logic [SW-1:0] r);
      steer_t p;
      if (held == WIN) begin
        left_total  -= left_ring[slot];
        right_total -= right_ring[slot];
      end
      left_ring[slot]  = l;
      right_ring[slot] = r;
      left_total  += l;
      right_total += r;
      slot = (slot == WIN - 1) ? 0 : slot + 1;
      if (held < WIN) held++;
      p.left_avg  = SW'(left_total / held);
      p.right_avg = SW'(right_total / held);
      p.err       = q15_balance(p.left_avg, p.right_avg);
      predicted_steer.push_back(p);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%t MISMATCH %s", $realtime, what);
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      steer_t        want;
      err_t          got_err;
      logic [SW-1:0] got_l;
      logic [SW-1:0] got_r;
      got_err = word[ERR_W-1:0];
      got_l   = word[ERR_W +: SW];
      got_r   = word[ERR_W+SW +: SW];
      if (predicted_steer.size() == 0) begin
        flag($sformatf("result with nothing pending: err=%0d left=%0d right=%0d",
                       $signed(got_err), got_l, got_r));
        return;
      end
      want = predicted_steer.pop_front();
      if (got_err !== want.err)
        flag($sformatf("steering_error exp=%0d got=%0d", $signed(want.err), $signed(got_err)));
      if (got_l !== want.left_avg)
        flag($sformatf("left_average exp=%0d got=%0d", want.left_avg, got_l));
      if (got_r !== want.right_avg)
        flag($sformatf("right_average exp=%0d got=%0d", want.right_avg, got_r));
    endfunction

    function int outstanding();
      return predicted_steer.size();
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  steering_checker board = new();
  int              sent  = 0;
  int              idle_cycles = 0;
  bit              quiet = 1'b0;

  dual_moving_average_diff_ratio #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SW)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // request/result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tdata[SW-1:0], s_tdata[2*SW-1:SW]);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic push_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_run();
    run_kind_t     kind;
    int            len;
    logic [SW-1:0] cl;
    logic [SW-1:0] cr;
    logic [SW-1:0] l;
    logic [SW-1:0] r;
    kind = run_kind_t'($urandom_range(0, 6));
    len  = $urandom_range(1, 12);
    cl   = SW'($urandom_range(0, 4095));
    cr   = SW'($urandom_range(0, 4095));
    for (int i = 0; i < len && sent < TOTAL; i++) begin
      quiet = (sent >= 300 && sent < 380) || sent >= 600;
      l = SW'($urandom_range(0, 4095));
      r = SW'($urandom_range(0, 4095));
      case (kind)
        RUN_SMALL: begin
          l = SW'($urandom_range(0, 7));
          r = SW'($urandom_range(0, 7));
        end
        RUN_STEADY: begin
          l = cl;
          r = cr;
        end
        RUN_RIGHT_DARK: r = '0;
        RUN_LEFT_DARK:  l = '0;
        RUN_DARK: begin
          l = '0;
          r = '0;
        end
        RUN_CLOSE: r = l ^ SW'($urandom_range(0, 3));
        default: ;
      endcase
      push_pair(l, r);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // warm-up with zeros, full-scale left, full-scale right, then dark ring
    push_pair('0, '0);
    repeat (WIN) push_pair('1, '0);
    repeat (WIN) push_pair('0, '1);
    repeat (WIN) push_pair('0, '0);
    s_tvalid <= 1'b0;
    settle();

    while (sent < TOTAL) random_run();
    s_tvalid <= 1'b0;
    settle();
    repeat (DRAIN) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
